### rtl/tsde_pkg.sv
`timescale 1ns / 1ps

package tsde_pkg;

  // Default sizes of one element and of one stack
  localparam int DATA_WIDTH_DEF = 32;
  localparam int SIDE_DEPTH_DEF = 256;

  // Field widths on the ports
  localparam int CMD_W      = 3;
  localparam int POS_W      = 9;
  localparam int VALUE_W    = 32;
  localparam int RDATA_W    = 32;
  localparam int COUNT_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ_IDX   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE_IDX  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_BACK  = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // Which stack delivers the read data of an item
  localparam logic [1:0] RSEL_NONE  = 2'd0;
  localparam logic [1:0] RSEL_FRONT = 2'd1;
  localparam logic [1:0] RSEL_BACK  = 2'd2;

  // Result of an item while its memory read completes
  typedef struct packed {
    logic [1:0]          rsel;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } tsde_res_t;

endpackage

### rtl/two_stack_deque_engine.sv
`timescale 1ns / 1ps

// Double-ended queue held as two stacks, each in its own single-port-per-side
// synchronous memory of SIDE_DEPTH entries. Every command item (push front,
// push back, read or write by index, read front, read back) gives exactly one
// result item carrying the read data, the element count, an empty flag and a
// status. An item's memory access is issued in the cycle it is accepted; the
// stack memory registers the read data, and the result then moves into the
// output register as soon as that register is free.
// One item is taken per cycle while the result side keeps up; a stalled result
// holds at most one further item in flight. The stacks need no clearing after
// reset: counts start at zero and no entry is read before it is written.
module two_stack_deque_engine
  import tsde_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int SIDE_DEPTH = SIDE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position [8:0], value [40:9]
  input  logic [CMD_W-1:0]       in_tuser,   // cmd [2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // read_data [31:0], count [41:32],
                                             // is_empty [42]
  output logic [STATUS_W-1:0]    out_tuser   // status [1:0]
);

  localparam int ADDR_W = $clog2(SIDE_DEPTH);
  localparam int CNT_W  = $clog2(SIDE_DEPTH + 1);
  localparam int TOT_W  = CNT_W + 1;
  localparam int CMP_W  = (TOT_W > POS_W) ? TOT_W : POS_W;

  // Input fields
  logic [CMD_W-1:0]   cmd;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  assign cmd      = in_tuser;
  assign position = in_tdata[POS_W-1:0];
  assign value    = in_tdata[POS_W+VALUE_W-1:POS_W];

  // Control state
  logic [CNT_W-1:0] front_cnt_r, front_cnt_nxt;
  logic [CNT_W-1:0] back_cnt_r,  back_cnt_nxt;
  logic             pend_r, pend_nxt;
  tsde_res_t        pend_res_r, pend_res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [STATUS_W-1:0]    out_tuser_r, out_tuser_nxt;

  // Memory requests
  logic                  f_we, f_re, b_we, b_re;
  logic [ADDR_W-1:0]     f_addr, b_addr;
  logic [DATA_WIDTH-1:0] wdata, f_rdata, b_rdata;

  logic                  accept, out_free;
  logic [TOT_W-1:0]      total, total_nxt;
  logic [CMP_W-1:0]      pos_w, total_w, front_w;
  logic [CMP_W-1:0]      f_idx, b_idx;
  logic                  in_range, in_front;
  logic [STATUS_W-1:0]   status;
  logic [1:0]            rsel;
  logic [RDATA_W-1:0]    rd_word;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !pend_r || out_free;
  assign accept    = in_tvalid && in_tready;

  assign total    = TOT_W'(front_cnt_r) + TOT_W'(back_cnt_r);
  assign pos_w    = CMP_W'(position);
  assign total_w  = CMP_W'(total);
  assign front_w  = CMP_W'(front_cnt_r);
  assign in_range = pos_w < total_w;
  assign in_front = pos_w < front_w;
  assign f_idx    = front_w - pos_w - CMP_W'(1);
  assign b_idx    = pos_w - front_w;
  assign wdata    = DATA_WIDTH'(value);

  // Decode the command, issue the memory access and update the counts
  always_comb begin
    front_cnt_nxt = front_cnt_r;
    back_cnt_nxt  = back_cnt_r;
    f_we   = 1'b0;
    f_re   = 1'b0;
    b_we   = 1'b0;
    b_re   = 1'b0;
    f_addr = '0;
    b_addr = '0;
    status = ST_OK;
    rsel   = RSEL_NONE;
    unique case (cmd) inside
      CMD_PUSH_FRONT: begin
        if (front_cnt_r == CNT_W'(SIDE_DEPTH)) begin
          status = ST_FULL;
        end else begin
          f_we          = accept;
          f_addr        = front_cnt_r[ADDR_W-1:0];
          front_cnt_nxt = front_cnt_r + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (back_cnt_r == CNT_W'(SIDE_DEPTH)) begin
          status = ST_FULL;
        end else begin
          b_we         = accept;
          b_addr       = back_cnt_r[ADDR_W-1:0];
          back_cnt_nxt = back_cnt_r + CNT_W'(1);
        end
      end
      CMD_READ_IDX, CMD_WRITE_IDX: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else if (in_front) begin
          f_addr = f_idx[ADDR_W-1:0];
          if (cmd == CMD_READ_IDX) begin
            f_re = accept;
            rsel = RSEL_FRONT;
          end else begin
            f_we = accept;
          end
        end else begin
          b_addr = b_idx[ADDR_W-1:0];
          if (cmd == CMD_READ_IDX) begin
            b_re = accept;
            rsel = RSEL_BACK;
          end else begin
            b_we = accept;
          end
        end
      end
      CMD_READ_FRONT: begin
        if (total == '0) begin
          status = ST_EMPTY;
        end else if (front_cnt_r != '0) begin
          f_re   = accept;
          f_addr = ADDR_W'(front_cnt_r - CNT_W'(1));
          rsel   = RSEL_FRONT;
        end else begin
          b_re = accept;
          rsel = RSEL_BACK;
        end
      end
      CMD_READ_BACK: begin
        if (total == '0) begin
          status = ST_EMPTY;
        end else if (back_cnt_r != '0) begin
          b_re   = accept;
          b_addr = ADDR_W'(back_cnt_r - CNT_W'(1));
          rsel   = RSEL_BACK;
        end else begin
          f_re = accept;
          rsel = RSEL_FRONT;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      front_cnt_nxt = front_cnt_r;
      back_cnt_nxt  = back_cnt_r;
    end
  end

  assign total_nxt = TOT_W'(front_cnt_nxt) + TOT_W'(back_cnt_nxt);

  // Hold the item's result while its read completes
  always_comb begin
    pend_res_nxt = pend_res_r;
    pend_nxt     = pend_r;
    if (accept) begin
      pend_nxt              = 1'b1;
      pend_res_nxt.rsel     = rsel;
      pend_res_nxt.status   = status;
      pend_res_nxt.count    = COUNT_W'(total_nxt);
      pend_res_nxt.is_empty = (total_nxt == '0);
    end else if (pend_r && out_free) begin
      pend_nxt = 1'b0;
    end
  end

  // Pick the read word from the stack that served it
  always_comb begin
    case (pend_res_r.rsel)
      RSEL_FRONT: rd_word = RDATA_W'(f_rdata);
      RSEL_BACK:  rd_word = RDATA_W'(b_rdata);
      default:    rd_word = '0;
    endcase
  end

  // Advance the result into the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    if (pend_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_tdata_nxt = OUT_TDATA_W'({pend_res_r.is_empty, pend_res_r.count, rd_word});
      out_tuser_nxt = pend_res_r.status;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_cnt_r <= '0;
      back_cnt_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_cnt_r <= front_cnt_nxt;
      back_cnt_r  <= back_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_res_r  <= pend_res_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Front stack: grows on push front
  tsde_stack_mem #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (SIDE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_front_mem (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_addr),
    .wdata (wdata),
    .re    (f_re),
    .raddr (f_addr),
    .rdata (f_rdata)
  );

  // Back stack: grows on push back
  tsde_stack_mem #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (SIDE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_back_mem (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_addr),
    .wdata (wdata),
    .re    (b_re),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

endmodule

### rtl/tsde_stack_mem.sv
`timescale 1ns / 1ps

module tsde_stack_mem #(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 256,
  parameter int ADDR_W     = 8
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, hold the data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tsde_pkg::*;

  // Commands the block decodes as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int DEPTH = SIDE_DEPTH_DEF;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } deque_cmd_t;

  typedef struct {
    logic [RDATA_W-1:0]  rdata;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } deque_res_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  two_stack_deque_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Commands waiting to be sent and results waiting to arrive
  deque_cmd_t cmd_backlog[$];
  deque_res_t pending_results[$];
  int         errors = 0;

  // Shadow copy of the deque, advanced as each item is accepted
  logic [VALUE_W-1:0] front_mem [DEPTH];
  logic [VALUE_W-1:0] back_mem  [DEPTH];
  int                 front_cnt = 0;
  int                 back_cnt = 0;

  // Stack sizes as seen by the stimulus generator
  int gen_front = 0;
  int gen_back = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Work out the result of one command and update the shadow deque
  task automatic apply_command(input deque_cmd_t it, output deque_res_t r);
    int total;
    int p;
    total = front_cnt + back_cnt;
    p = int'(it.pos);
    r.rdata = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_PUSH_FRONT: begin
        if (front_cnt >= DEPTH) r.status = ST_FULL;
        else begin
          front_mem[front_cnt] = it.value;
          front_cnt++;
        end
      end
      CMD_PUSH_BACK: begin
        if (back_cnt >= DEPTH) r.status = ST_FULL;
        else begin
          back_mem[back_cnt] = it.value;
          back_cnt++;
        end
      end
      CMD_READ_IDX: begin
        if (p >= total) r.status = ST_RANGE;
        else if (p < front_cnt) r.rdata = front_mem[front_cnt - 1 - p];
        else r.rdata = back_mem[p - front_cnt];
      end
      CMD_WRITE_IDX: begin
        if (p >= total) r.status = ST_RANGE;
        else if (p < front_cnt) front_mem[front_cnt - 1 - p] = it.value;
        else back_mem[p - front_cnt] = it.value;
      end
      CMD_READ_FRONT: begin
        if (total == 0) r.status = ST_EMPTY;
        else if (front_cnt > 0) r.rdata = front_mem[front_cnt - 1];
        else r.rdata = back_mem[0];
      end
      CMD_READ_BACK: begin
        // An empty back stack falls back to the bottom of the front stack
        if (total == 0) r.status = ST_EMPTY;
        else if (back_cnt > 0) r.rdata = back_mem[back_cnt - 1];
        else r.rdata = front_mem[0];
      end
      default: ;
    endcase
    total = front_cnt + back_cnt;
    r.count = COUNT_W'(total);
    r.is_empty = (total == 0);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // Idle length: mostly none or short, a few long, with calm stretches
  function automatic int pick_idle(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: present the oldest backlog item, hold it until taken
  int tx_gap = 0;
  int tx_calm = 0;
  always @(posedge clk) begin
    deque_res_t res;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_command(cmd_backlog.pop_front(), res);
        pending_results.push_back(res);
        tx_gap = pick_idle(tx_calm);
      end
      if (in_tvalid && !in_tready) begin
        // hold the current item
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, cmd_backlog[0].value, cmd_backlog[0].pos};
        in_tuser  <= cmd_backlog[0].cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each result item against the oldest expectation
  int rx_stall = 0;
  int rx_calm = 0;
  always @(posedge clk) begin
    deque_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_tdata), 64'h0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[31:0] !== want.rdata)
            report_mismatch("read_data", 64'(out_tdata[31:0]), 64'(want.rdata));
          if (out_tdata[41:32] !== want.count)
            report_mismatch("count", 64'(out_tdata[41:32]), 64'(want.count));
          if (out_tdata[42] !== want.is_empty)
            report_mismatch("is_empty", 64'(out_tdata[42]), 64'(want.is_empty));
          if (out_tuser !== want.status)
            report_mismatch("status", 64'(out_tuser), 64'(want.status));
        end
        rx_stall = pick_idle(rx_calm);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Queue one command and track the stack sizes it leads to
  task automatic add_cmd(input logic [CMD_W-1:0] c, input int pos,
                         input logic [VALUE_W-1:0] v);
    deque_cmd_t it;
    it.cmd = c;
    it.pos = POS_W'(pos);
    it.value = v;
    cmd_backlog.push_back(it);
    if (c == CMD_PUSH_FRONT && gen_front < DEPTH) gen_front++;
    if (c == CMD_PUSH_BACK && gen_back < DEPTH) gen_back++;
  endtask

  // Random command; wide_pct is the share of positions drawn over the full range
  task automatic add_mixed(input int push_pct, input int wide_pct);
    logic [CMD_W-1:0] c;
    int r;
    int total;
    int pos;
    total = gen_front + gen_back;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 35) c = CMD_READ_IDX;
      else if (r < 70) c = CMD_WRITE_IDX;
      else if (r < 84) c = CMD_READ_FRONT;
      else if (r < 97) c = CMD_READ_BACK;
      else c = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
    end
    if (total > 0 && $urandom_range(0, 99) >= wide_pct)
      pos = $urandom_range(0, total - 1);
    else
      pos = $urandom_range(0, 511);
    add_cmd(c, pos, $urandom);
  endtask

  initial begin
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty deque, out-of-range access and spare commands
    add_cmd(CMD_READ_FRONT, 0, 32'h0);
    add_cmd(CMD_READ_BACK, 511, 32'hFFFF_FFFF);
    add_cmd(CMD_READ_IDX, 0, 32'h0);
    add_cmd(CMD_WRITE_IDX, 511, 32'hFFFF_FFFF);
    add_cmd(CMD_SPARE_6, 0, 32'h0);
    add_cmd(CMD_SPARE_7, 511, 32'hFFFF_FFFF);
    // Front stack only: read back falls back to its bottom entry
    add_cmd(CMD_PUSH_FRONT, 0, 32'hFFFF_FFFF);
    add_cmd(CMD_READ_BACK, 0, 32'h0);
    add_cmd(CMD_READ_FRONT, 0, 32'h0);
    add_cmd(CMD_PUSH_FRONT, 511, 32'h0000_0000);
    add_cmd(CMD_READ_BACK, 0, 32'h0);
    add_cmd(CMD_READ_IDX, 0, 32'h0);
    add_cmd(CMD_READ_IDX, 1, 32'h0);
    add_cmd(CMD_READ_IDX, 2, 32'h0);
    // Both stacks in use, index crossing from front to back
    add_cmd(CMD_PUSH_BACK, 0, 32'h1234_5678);
    add_cmd(CMD_READ_BACK, 0, 32'h0);
    add_cmd(CMD_WRITE_IDX, 0, 32'hDEAD_BEEF);
    add_cmd(CMD_WRITE_IDX, 2, 32'h0000_0000);
    add_cmd(CMD_READ_IDX, 0, 32'h0);
    add_cmd(CMD_READ_IDX, 2, 32'h0);
    add_cmd(CMD_READ_FRONT, 0, 32'h0);
    add_cmd(CMD_READ_BACK, 0, 32'h0);
    add_cmd(CMD_WRITE_IDX, 3, 32'hA5A5_A5A5);

    // Hold off until the directed part has fully drained
    while (cmd_backlog.size() != 0 || pending_results.size() != 0) @(posedge clk);

    // Mixed traffic while the deque grows
    repeat (150) add_mixed(40, 20);

    // Fill both stacks, with reads and writes scattered between pushes
    while (gen_front < DEPTH || gen_back < DEPTH) begin
      if ($urandom_range(0, 99) < 15) begin
        add_mixed(0, 5);
      end else if (gen_front >= DEPTH) begin
        add_cmd(CMD_PUSH_BACK, $urandom_range(0, 511), $urandom);
      end else if (gen_back >= DEPTH) begin
        add_cmd(CMD_PUSH_FRONT, $urandom_range(0, 511), $urandom);
      end else begin
        r = $urandom_range(0, 1);
        add_cmd(r ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom_range(0, 511), $urandom);
      end
    end

    // Full deque: every position valid, every push dropped
    repeat (100) add_mixed(25, 100);

    while (cmd_backlog.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
